// ===== src/u2cp_pkg.sv =====
package u2cp_pkg;

  localparam int unsigned UnitW  = 16;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned PendW  = 2;
  localparam int unsigned SurrW  = 10;
  localparam int unsigned SurrSelW = UnitW - SurrW;

  localparam logic              EncUtf8  = 1'b0;
  localparam logic              EncUtf16 = 1'b1;

  localparam logic [PendW-1:0]  PendNone = 2'd0;
  localparam logic [PendW-1:0]  PendOne  = 2'd1;
  localparam logic [PendW-1:0]  PendTwo  = 2'd2;
  localparam logic [PendW-1:0]  PendThree = 2'd3;

  localparam logic [1:0]          ContTag  = 2'b10;
  localparam logic [SurrSelW-1:0] HighSurr = 6'b110110;
  localparam logic [SurrSelW-1:0] LowSurr  = 6'b110111;
  localparam logic [CpW-1:0]      SuppBase = 21'h010000;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             end_of_string;
  } in_word_t;

  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
  } result_t;

endpackage

// ===== src/u2cp_in_reg.sv =====
module u2cp_in_reg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u2cp_pkg::in_word_t    in_word,
  input  logic                  take,
  output logic                  valid_r,
  output u2cp_pkg::in_word_t    word_r
);
  import u2cp_pkg::*;

  assign in_stall = valid_r && !take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      word_r <= in_word;
    end
  end

endmodule

// ===== src/u2cp_step.sv =====
module u2cp_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic                  cfg_wr_data,
  input  logic                  valid,
  input  u2cp_pkg::in_word_t    word,
  input  logic                  out_space,
  output logic                  take,
  output u2cp_pkg::result_t     result
);
  import u2cp_pkg::*;

  logic             enc_r;
  logic [PendW-1:0] pend_r, pend_nxt;
  logic [CpW-1:0]   bits_r, bits_nxt;
  logic             got;
  logic [CpW-1:0]   cp;
  logic [ByteW-1:0] b;
  logic [UnitW-1:0] u;

  assign b = word.code_unit[ByteW-1:0];
  assign u = word.code_unit;

  always_comb begin
    got      = 1'b0;
    cp       = '0;
    pend_nxt = pend_r;
    bits_nxt = bits_r;
    if (enc_r == EncUtf8) begin
      if (pend_r != PendNone) begin
        if (b[7:6] != ContTag) begin
          pend_nxt = PendNone;
          bits_nxt = '0;
        end else begin
          pend_nxt = pend_r - PendOne;
          if (pend_r == PendOne) begin
            got      = 1'b1;
            cp       = {bits_r[CpW-7:0], b[5:0]};
            bits_nxt = '0;
          end else begin
            bits_nxt = {bits_r[CpW-7:0], b[5:0]};
          end
        end
      end else begin
        unique case (b) inside
          8'b0???????: begin
            got = 1'b1;
            cp  = CpW'(b);
          end
          8'b110?????: begin
            pend_nxt = PendOne;
            bits_nxt = CpW'(b[4:0]);
          end
          8'b1110????: begin
            pend_nxt = PendTwo;
            bits_nxt = CpW'(b[3:0]);
          end
          8'b11110???: begin
            pend_nxt = PendThree;
            bits_nxt = CpW'(b[2:0]);
          end
          default: ;
        endcase
      end
    end else begin
      if (pend_r != PendNone) begin
        pend_nxt = PendNone;
        bits_nxt = '0;
        if (u[UnitW-1:SurrW] == LowSurr) begin
          got = 1'b1;
          cp  = CpW'({bits_r[SurrW-1:0], u[SurrW-1:0]}) + SuppBase;
        end
      end else if (u[UnitW-1:SurrW] == HighSurr) begin
        pend_nxt = PendOne;
        bits_nxt = CpW'(u[SurrW-1:0]);
      end else begin
        got = 1'b1;
        cp  = CpW'(u);
      end
    end
    if (word.end_of_string) begin
      pend_nxt = PendNone;
      bits_nxt = '0;
    end
  end

  assign take              = valid && (!got || out_space);
  assign result.valid      = take && got;
  assign result.code_point = cp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r  <= EncUtf8;
      pend_r <= PendNone;
      bits_r <= '0;
    end else if (cfg_wr_en) begin
      enc_r  <= cfg_wr_data;
      pend_r <= PendNone;
      bits_r <= '0;
    end else if (take) begin
      pend_r <= pend_nxt;
      bits_r <= bits_nxt;
    end
  end

endmodule

// ===== src/u2cp_out_reg.sv =====
module u2cp_out_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  u2cp_pkg::result_t             result,
  output logic                          out_space,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u2cp_pkg::CpW-1:0]      out_code_point
);
  import u2cp_pkg::*;

  logic           valid_r;
  logic [CpW-1:0] cp_r;

  assign out_space      = !valid_r || !out_stall;
  assign out_valid      = valid_r;
  assign out_code_point = cp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_space) begin
      valid_r <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_space && result.valid) begin
      cp_r <= result.code_point;
    end
  end

endmodule

// ===== src/utf8_utf16_code_point_decoder.sv =====
// channel | ports                                   | moves
// --------+-----------------------------------------+------------------------------
// in      | in_valid, in_stall, in_code_unit,       | one code unit word
//         | in_end_of_string                        |
// out     | out_valid, out_stall, out_code_point    | one code point word
// cfg     | cfg_wr_en, cfg_wr_data                  | source encoding, 1 = UTF-16
//
// One word per cycle sustained while out_stall is low.
// Rate is set by the single decode step between input and result registers.
// Reset: synchronous, active low; encoding returns to UTF-8, nothing pending.
// out_stall holds the result register; words with no result still drain.
module utf8_utf16_code_point_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [u2cp_pkg::UnitW-1:0]    in_code_unit,
  input  logic                          in_end_of_string,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [u2cp_pkg::CpW-1:0]      out_code_point
);
  import u2cp_pkg::*;

  in_word_t in_word, word_r;
  logic     valid_r;
  logic     take;
  logic     out_space;
  result_t  result;

  assign in_word.code_unit     = in_code_unit;
  assign in_word.end_of_string = in_end_of_string;

  u2cp_in_reg u_in (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word (in_word),
    .take    (take),
    .valid_r (valid_r),
    .word_r  (word_r)
  );

  u2cp_step u_step (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .valid      (valid_r),
    .word       (word_r),
    .out_space  (out_space),
    .take       (take),
    .result     (result)
  );

  u2cp_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .result        (result),
    .out_space     (out_space),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code_point(out_code_point)
  );

endmodule
